// ===== rtl/array_stack_and_bag_defines.svh =====
// Assertion macros for the array stack and bag block.
`ifndef ARRAY_STACK_AND_BAG_DEFINES_SVH
`define ARRAY_STACK_AND_BAG_DEFINES_SVH

`ifndef SYNTH
`define ASB_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASB_ASSERT_ALWAYS(label, prop, msg)
`define ASB_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/asb_pkg.sv =====
// Shared constants, codes and controller/datapath interface types.
package asb_pkg;

	localparam int DEPTH = 16;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int IW    = (CW > 4) ? CW : 4;

	typedef enum logic [3:0] {
		K_PUSH      = 4'd0,
		K_POP       = 4'd1,
		K_TOP       = 4'd2,
		K_GET       = 4'd3,
		K_PUT       = 4'd4,
		K_SWAP      = 4'd5,
		K_REMOVE_AT = 4'd6,
		K_CONTAINS  = 4'd7,
		K_REMOVE_VAL = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_SWAP_B,
		S_SWAP_WA,
		S_SWAP_WB,
		S_SEARCH,
		S_SHIFT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic    load_req;
		logic    clr_res;
		logic    push_wr;
		logic    put_wr;
		logic    dec_count;
		logic    rd_top;
		logic    rd_a;
		logic    rd_b;
		logic    cap_rd;
		logic    cap_tmp;
		logic    wr_a_rdata;
		logic    wr_b_tmp;
		logic    set_st;
		status_t st;
		logic    set_found;
		logic    search_start;
		logic    search_step;
		logic    shift_start_a;
		logic    shift_from_match;
		logic    shift_step;
		logic    load_out;
	} cmd_t;

	typedef struct packed {
		logic [3:0]    kind;
		logic          full;
		logic          empty;
		logic          a_oob;
		logic          b_oob;
		logic          hit;
		logic          scan_end;
		logic          out_free;
		logic [CW-1:0] count;
	} stat_t;

endpackage

// ===== rtl/array_stack_and_bag.sv =====
// Top level of the array stack and bag: controller, datapath and checks.
//
//  group  dir  tdata (low bit up)                              tuser
//  s_*    in   index_a[3:0] index_b[7:4] value[39:8]           kind[3:0]
//  m_*    out  read_value[31:0] found[32] status[34:33]        -
//              count[39:35] empty_res[40], zero to 47
//
// One request at a time. Push, pop, put and range or empty refusals pass through
// decode to the result; top and get also pass a read state; swap reads both entries
// and writes them back. Remove_at, contains and remove_value walk the entry memory
// one entry per cycle, over at most the current count of entries. A new request is
// taken while the previous result still waits in the output register. Reset clears
// the count; entries are not cleared and need no clearing pass.
`include "array_stack_and_bag_defines.svh"

module array_stack_and_bag import asb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // index_a, index_b, value
	input  logic [3:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // read_value, found, status, count, empty_res
);

	cmd_t  cmd;
	stat_t st;

	asb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	asb_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.kind     (s_tuser),
		.index_a  (s_tdata[3:0]),
		.index_b  (s_tdata[7:4]),
		.value    (s_tdata[39:8]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	`ASB_ASSERT_ALWAYS(a_count_range, st.count <= CW'(DEPTH), "count above capacity")
	`ASB_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while busy")
	`ASB_ASSERT_NEXT(a_dec_count, cmd.dec_count, st.count == $past(st.count) - 1'b1, "count drop")

endmodule

// ===== rtl/asb_ctrl.sv =====
// Sequencer for the array stack and bag: decodes a request and steps the datapath.
module asb_ctrl import asb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.st   = ST_OK;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.clr_res = 1'b1;
				state_d     = S_RESP;
				unique case (kind_t'(st.kind))
					K_PUSH: begin
						if (st.full) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_FULL;
						end else begin
							cmd.push_wr = 1'b1;
						end
					end
					K_POP: begin
						if (st.empty) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_EMPTY;
						end else begin
							cmd.dec_count = 1'b1;
						end
					end
					K_TOP: begin
						if (st.empty) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_EMPTY;
						end else begin
							cmd.rd_top = 1'b1;
							state_d    = S_READ;
						end
					end
					K_GET: begin
						if (st.a_oob) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_RANGE;
						end else begin
							cmd.rd_a = 1'b1;
							state_d  = S_READ;
						end
					end
					K_PUT: begin
						if (st.a_oob) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_RANGE;
						end else begin
							cmd.put_wr = 1'b1;
						end
					end
					K_SWAP: begin
						if (st.a_oob || st.b_oob) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_RANGE;
						end else begin
							cmd.rd_a = 1'b1;
							state_d  = S_SWAP_B;
						end
					end
					K_REMOVE_AT: begin
						if (st.a_oob) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_RANGE;
						end else begin
							cmd.shift_start_a = 1'b1;
							state_d           = S_SHIFT;
						end
					end
					K_CONTAINS, K_REMOVE_VAL: begin
						cmd.search_start = 1'b1;
						state_d          = S_SEARCH;
					end
					default: begin
						// unused kinds: plain ok response
					end
				endcase
			end
			S_READ: begin
				cmd.cap_rd = 1'b1;
				state_d    = S_RESP;
			end
			S_SWAP_B: begin
				cmd.rd_b    = 1'b1;
				cmd.cap_tmp = 1'b1;
				state_d     = S_SWAP_WA;
			end
			S_SWAP_WA: begin
				cmd.wr_a_rdata = 1'b1;
				state_d        = S_SWAP_WB;
			end
			S_SWAP_WB: begin
				cmd.wr_b_tmp = 1'b1;
				state_d      = S_RESP;
			end
			S_SEARCH: begin
				if (st.hit) begin
					cmd.set_found = 1'b1;
					if (kind_t'(st.kind) == K_REMOVE_VAL) begin
						cmd.shift_from_match = 1'b1;
						state_d              = S_SHIFT;
					end else begin
						state_d = S_RESP;
					end
				end else if (st.scan_end) begin
					state_d = S_RESP;
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			S_SHIFT: begin
				if (st.scan_end) begin
					cmd.dec_count = 1'b1;
					state_d       = S_RESP;
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			S_RESP: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/asb_dp.sv =====
// Datapath: entry memory, count, walk pointers, result and output registers.
module asb_dp import asb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       st,
	input  logic [3:0]  kind,
	input  logic [3:0]  index_a,
	input  logic [3:0]  index_b,
	input  logic [31:0] value,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata
);

	logic [31:0]   mem [DEPTH];
	logic [31:0]   rdata_q;
	logic [3:0]    kind_q;
	logic [3:0]    ia_q;
	logic [3:0]    ib_q;
	logic [31:0]   val_q;
	logic [31:0]   tmp_q;
	logic [31:0]   rd_q;
	logic          found_q;
	status_t       status_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rptr_q;
	logic [AW-1:0] paddr_q;
	logic          pend_q;
	logic          out_vld_q;
	logic [47:0]   out_q;

	logic [AW-1:0] a_addr;
	logic [AW-1:0] b_addr;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic          we;
	logic          step;
	logic          more;
	logic          issue;

	assign a_addr = AW'(IW'(ia_q));
	assign b_addr = AW'(IW'(ib_q));
	assign step   = cmd.search_step | cmd.shift_step;
	assign more   = rptr_q < count_q;
	assign issue  = step & more;

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = rdata_q;
		priority if (cmd.push_wr) begin
			we    = 1'b1;
			waddr = AW'(count_q);
			wdata = val_q;
		end else if (cmd.put_wr) begin
			we    = 1'b1;
			waddr = a_addr;
			wdata = val_q;
		end else if (cmd.wr_a_rdata) begin
			we    = 1'b1;
			waddr = a_addr;
		end else if (cmd.wr_b_tmp) begin
			we    = 1'b1;
			waddr = b_addr;
			wdata = tmp_q;
		end else if (cmd.shift_step && pend_q) begin
			// entry just read moves down one place
			we    = 1'b1;
			waddr = paddr_q - 1'b1;
		end
	end

	always_comb begin
		raddr = '0;
		priority if (cmd.rd_top) begin
			raddr = AW'(count_q - 1'b1);
		end else if (cmd.rd_a) begin
			raddr = a_addr;
		end else if (cmd.rd_b) begin
			raddr = b_addr;
		end else if (step) begin
			raddr = AW'(rptr_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rptr_q    <= '0;
			pend_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.push_wr) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.dec_count) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.search_start) begin
				rptr_q <= '0;
				pend_q <= 1'b0;
			end else if (cmd.shift_start_a) begin
				rptr_q <= CW'(IW'(ia_q) + 1'b1);
				pend_q <= 1'b0;
			end else if (cmd.shift_from_match) begin
				// shift starts just above the matching entry
				rptr_q <= CW'(paddr_q) + 1'b1;
				pend_q <= 1'b0;
			end else if (step) begin
				pend_q <= issue;
				if (issue) begin
					rptr_q <= rptr_q + 1'b1;
				end
			end
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q <= kind;
			ia_q   <= index_a;
			ib_q   <= index_b;
			val_q  <= value;
		end
		if (issue) begin
			paddr_q <= AW'(rptr_q);
		end
		if (cmd.cap_tmp) begin
			tmp_q <= rdata_q;
		end
		if (cmd.clr_res) begin
			rd_q     <= '0;
			found_q  <= 1'b0;
			status_q <= cmd.set_st ? cmd.st : ST_OK;
		end
		if (cmd.cap_rd) begin
			rd_q <= rdata_q;
		end
		if (cmd.set_found) begin
			found_q <= 1'b1;
		end
		if (cmd.load_out) begin
			out_q <= {7'd0, (count_q == '0), 5'(count_q), status_q, found_q, rd_q};
		end
	end

	assign st.kind     = kind_q;
	assign st.full     = count_q == CW'(DEPTH);
	assign st.empty    = count_q == '0;
	assign st.a_oob    = IW'(ia_q) >= IW'(count_q);
	assign st.b_oob    = IW'(ib_q) >= IW'(count_q);
	assign st.hit      = pend_q && (rdata_q == val_q);
	assign st.scan_end = !more && !pend_q;
	assign st.out_free = !out_vld_q || m_tready;
	assign st.count    = count_q;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule

// ===== bench/array_stack_and_bag_checker.sv =====
// Checker for the array stack and bag: tracks the entries and compares each result.
`timescale 1ns / 100ps

module array_stack_and_bag_checker import asb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // index_a, index_b, value
	input  logic [3:0]  s_tuser,   // kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // read_value, found, status, count, empty_res
	output int          fail_count,
	output int          outstanding
);

	// same bit order as m_tdata[40:0]
	typedef struct packed {
		logic          empty_res;
		logic [CW-1:0] count;
		status_t       status;
		logic          found;
		logic [31:0]   read_value;
	} bag_result_t;

	logic [31:0]  entries [DEPTH];
	int unsigned  fill;
	bag_result_t  pending_results[$];

	// delete one entry, later entries move down
	function automatic void drop_entry(int unsigned pos);
		for (int unsigned k = pos; k + 1 < fill; k++)
			entries[k] = entries[k + 1];
		fill--;
	endfunction

	function automatic bag_result_t apply_request(logic [3:0] kind, logic [3:0] ia,
			logic [3:0] ib, logic [31:0] val);
		bag_result_t r;
		logic [31:0] held;
		int unsigned hit_pos;
		r = '0;
		r.status = ST_OK;
		hit_pos = 0;
		case (kind)
		K_PUSH: begin
			if (fill >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				entries[fill] = val;
				fill++;
			end
		end
		K_POP: begin
			if (fill == 0) r.status = ST_EMPTY;
			else fill--;
		end
		K_TOP: begin
			if (fill == 0) r.status = ST_EMPTY;
			else r.read_value = entries[fill - 1];
		end
		K_GET: begin
			if (ia >= fill) r.status = ST_RANGE;
			else r.read_value = entries[ia];
		end
		K_PUT: begin
			if (ia >= fill) r.status = ST_RANGE;
			else entries[ia] = val;
		end
		K_SWAP: begin
			if (ia >= fill || ib >= fill) begin
				r.status = ST_RANGE;
			end else begin
				held = entries[ia];
				entries[ia] = entries[ib];
				entries[ib] = held;
			end
		end
		K_REMOVE_AT: begin
			if (ia >= fill) r.status = ST_RANGE;
			else drop_entry(ia);
		end
		K_CONTAINS, K_REMOVE_VAL: begin
			for (int unsigned k = 0; k < fill && !r.found; k++) begin
				if (entries[k] == val) begin
					r.found = 1'b1;
					hit_pos = k;
				end
			end
			// only the first match goes
			if (r.found && kind == K_REMOVE_VAL)
				drop_entry(hit_pos);
		end
		default: ;
		endcase
		r.count = CW'(fill);
		r.empty_res = (fill == 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bag_result_t got, want;
		int misses;
		if (!arst_n) begin
			fill = 0;
			pending_results.delete();
			foreach (entries[i])
				entries[i] = '0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			misses = 0;
			if (m_tvalid && m_tready) begin
				got = bag_result_t'(m_tdata[40:0]);
				if (pending_results.size() == 0) begin
					$error("result with no request outstanding: %h", m_tdata);
					misses++;
				end else begin
					want = pending_results.pop_front();
					if (got.read_value !== want.read_value) begin
						$error("read_value: expected %h, actual %h",
							want.read_value, got.read_value);
						misses++;
					end
					if (got.found !== want.found) begin
						$error("found: expected %b, actual %b", want.found, got.found);
						misses++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						misses++;
					end
					if (got.count !== want.count) begin
						$error("count: expected %0d, actual %0d", want.count, got.count);
						misses++;
					end
					if (got.empty_res !== want.empty_res) begin
						$error("empty_res: expected %b, actual %b",
							want.empty_res, got.empty_res);
						misses++;
					end
				end
			end
			if (s_tvalid && s_tready)
				pending_results.push_back(apply_request(s_tuser, s_tdata[3:0],
					s_tdata[7:4], s_tdata[39:8]));
			fail_count <= fail_count + misses;
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== bench/array_stack_and_bag_test.sv =====
// Top of the array stack and bag bench: clock, reset, request traffic and verdict.
`timescale 1ns / 100ps

module array_stack_and_bag_test;
	import asb_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BLOCKS  = 19;
	localparam int BLOCK_LEN      = 100;
	localparam int DRAIN_CYCLES   = 40;   // slack after the last result

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic [3:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	int fail_count;
	int outstanding;
	int idle_cycles = 0;
	int stall_left  = 0;
	bit tx_steady   = 1'b0;
	bit rx_steady   = 1'b0;

	logic [31:0] value_pool [8];

	array_stack_and_bag uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	array_stack_and_bag_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		return ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (rx_steady || $urandom_range(0, 4) != 0) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= 1'b0;
			stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("array_stack_and_bag verification failed");
			$finish;
		end
	end

	// valid stays up across back-to-back requests; it drops only for a gap or a drain
	task automatic send_request(input logic [3:0] kind, input logic [3:0] ia,
			input logic [3:0] ib, input logic [31:0] val);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {val, ib, ia};
		do @(posedge clk); while (!s_tready);
		gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		return ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 7)] : $urandom;
	endfunction

	function automatic logic [3:0] pick_index();
		return ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 7));
	endfunction

	initial begin
		int push_pct, pop_pct, r;
		logic [3:0] kind;
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		value_pool[2] = 32'h7FFF_FFFF;
		value_pool[3] = 32'h8000_0000;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty array refusals
		send_request(K_POP, 4'd0, 4'd0, 32'h0);
		send_request(K_TOP, 4'd0, 4'd0, 32'h0);
		send_request(K_GET, 4'd0, 4'd0, 32'h0);
		send_request(K_REMOVE_AT, 4'd0, 4'd0, 32'h0);
		send_request(K_CONTAINS, 4'd0, 4'd0, 32'h0);
		send_request(K_REMOVE_VAL, 4'd0, 4'd0, 32'h0);
		// extremes of the value field
		send_request(K_PUSH, 4'd0, 4'd0, 32'h7FFF_FFFF);
		send_request(K_PUSH, 4'd0, 4'd0, 32'h8000_0000);
		send_request(K_PUSH, 4'd0, 4'd0, 32'hFFFF_FFFF);
		send_request(K_PUSH, 4'd0, 4'd0, 32'h0000_0000);
		send_request(K_TOP, 4'd0, 4'd0, 32'h0);
		send_request(K_GET, 4'd0, 4'd0, 32'h0);
		send_request(K_GET, 4'd15, 4'd0, 32'h0);
		send_request(K_PUT, 4'd1, 4'd0, 32'h1234_5678);
		send_request(K_SWAP, 4'd0, 4'd3, 32'h0);
		send_request(K_SWAP, 4'd15, 4'd0, 32'h0);
		send_request(K_SWAP, 4'd0, 4'd15, 32'h0);
		send_request(K_CONTAINS, 4'd0, 4'd0, 32'h8000_0000);
		send_request(K_REMOVE_VAL, 4'd0, 4'd0, 32'hFFFF_FFFF);
		send_request(K_REMOVE_VAL, 4'd0, 4'd0, 32'h5555_AAAA);
		send_request(K_REMOVE_AT, 4'd0, 4'd0, 32'h0);
		send_request(K_PUT, 4'd15, 4'd15, 32'hFFFF_FFFF);
		send_request(4'(K_REMOVE_VAL + 1), 4'd0, 4'd0, 32'h0);
		send_request('1, '1, '1, '1);
		send_request(K_POP, 4'd0, 4'd0, 32'h0);

		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			// let the block drain fully before each new traffic mix
			wait_all_results();
			tx_steady = (blk % 5 == 4);
			rx_steady = (blk % 7 == 3);
			case (blk % 3)
			0: begin push_pct = 55; pop_pct = 5; end    // fill up to full
			1: begin push_pct = 5; pop_pct = 50; end    // drain to empty
			default: begin push_pct = 25; pop_pct = 20; end
			endcase
			for (int n = 0; n < BLOCK_LEN; n++) begin
				r = $urandom_range(0, 99);
				if (r < push_pct)
					kind = K_PUSH;
				else if (r < push_pct + pop_pct)
					kind = K_POP;
				else if (r < 97)
					kind = 4'($urandom_range(K_TOP, K_REMOVE_VAL));
				else
					kind = 4'($urandom_range(K_REMOVE_VAL + 1, 15));
				send_request(kind, pick_index(), pick_index(), pick_value());
			end
		end

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("array_stack_and_bag verification clean");
		else
			$display("array_stack_and_bag verification failed");
		$finish;
	end

endmodule

// ===== array_stack_and_bag.f =====
+incdir+rtl
rtl/asb_pkg.sv
rtl/asb_ctrl.sv
rtl/asb_dp.sv
rtl/array_stack_and_bag.sv
bench/array_stack_and_bag_checker.sv
bench/array_stack_and_bag_test.sv
